FILE: rtl/core/ambient_light_lux_calc_assert.svh
// Assertion macros for the ambient light lux calculator, clocked on clk_i and reset by rst_ni.
`ifndef AMBIENT_LIGHT_LUX_CALC_ASSERT_SVH
`define AMBIENT_LIGHT_LUX_CALC_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define ALC_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("ambient light lux check failed");

// A condition that, once seen, must be followed by another one in the next cycle.
`define ALC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ambient light lux sequence check failed");

`endif

FILE: rtl/core/alc_pkg.sv
// Shared types, constants and decode functions of the ambient light lux calculator.
`default_nettype none

package alc_pkg;

  localparam int unsigned COEF_FRAC_BITS = 14;
  localparam int unsigned OUT_FRAC_BITS  = 8;

  localparam int unsigned CNT_W    = 16;
  localparam int unsigned TOTAL_W  = CNT_W + 1;
  localparam int unsigned CMP_W    = TOTAL_W + 7;
  localparam int unsigned COEF_W   = COEF_FRAC_BITS + 3;
  localparam int unsigned PROD_W   = COEF_W + CNT_W;
  localparam int unsigned SUM_W    = PROD_W + 1;
  localparam int unsigned NUM_W    = SUM_W + OUT_FRAC_BITS + 1;
  localparam int unsigned EXT_W    = (NUM_W > 33) ? NUM_W : 33;
  localparam int unsigned LUX_W    = 27;
  localparam int unsigned Y_W      = 32;
  localparam int unsigned ODD_W    = 5;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned CFG_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG = 2'd1;

  // Gain codes.
  localparam logic [CFG_W-1:0] GAIN_X1   = 3'd0;
  localparam logic [CFG_W-1:0] GAIN_X2   = 3'd1;
  localparam logic [CFG_W-1:0] GAIN_X4   = 3'd2;
  localparam logic [CFG_W-1:0] GAIN_X8   = 3'd3;
  localparam logic [CFG_W-1:0] GAIN_RSV4 = 3'd4;
  localparam logic [CFG_W-1:0] GAIN_RSV5 = 3'd5;
  localparam logic [CFG_W-1:0] GAIN_X48  = 3'd6;
  localparam logic [CFG_W-1:0] GAIN_X96  = 3'd7;

  // Integration time codes, named by their factor.
  localparam logic [CFG_W-1:0] INTEG_T1  = 3'd0;
  localparam logic [CFG_W-1:0] INTEG_T05 = 3'd1;
  localparam logic [CFG_W-1:0] INTEG_T2  = 3'd2;
  localparam logic [CFG_W-1:0] INTEG_T4  = 3'd3;
  localparam logic [CFG_W-1:0] INTEG_T15 = 3'd4;
  localparam logic [CFG_W-1:0] INTEG_T25 = 3'd5;
  localparam logic [CFG_W-1:0] INTEG_T3  = 3'd6;
  localparam logic [CFG_W-1:0] INTEG_T35 = 3'd7;

  // Infrared share thresholds in percent.
  localparam logic [CMP_W-1:0] SHARE_SCALE = 24'd100;
  localparam logic [CMP_W-1:0] SHARE_LOW   = 24'd45;
  localparam logic [CMP_W-1:0] SHARE_MID   = 24'd64;
  localparam logic [CMP_W-1:0] SHARE_HIGH  = 24'd85;

  // Formula coefficients, rounded half up from four decimal places.
  localparam logic [COEF_W-1:0] COEF_A0 =
    COEF_W'(((64'd17743 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] COEF_B0 =
    COEF_W'(((64'd11059 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] COEF_A1 =
    COEF_W'(((64'd42785 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] COEF_B1 =
    COEF_W'(((64'd19548 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] COEF_A2 =
    COEF_W'(((64'd5926 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] COEF_B2 =
    COEF_W'(((64'd1185 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);

  localparam logic [LUX_W-1:0] LUX_MAX = '1;

  // Largest odd denominator part; clamping the dividend here keeps every
  // saturating quotient saturating.
  localparam longint unsigned MAX_ODD = 64'd21;
  localparam logic [Y_W-1:0]  Y_CLAMP = Y_W'(MAX_ODD << LUX_W);

  // Reciprocals floor((2^32-1)/m) of the odd denominator parts.
  localparam longint unsigned RECIP_ONE = (64'd1 << Y_W) - 64'd1;
  localparam logic [Y_W-1:0] RECIP_1  = Y_W'(RECIP_ONE);
  localparam logic [Y_W-1:0] RECIP_3  = Y_W'(RECIP_ONE / 64'd3);
  localparam logic [Y_W-1:0] RECIP_5  = Y_W'(RECIP_ONE / 64'd5);
  localparam logic [Y_W-1:0] RECIP_7  = Y_W'(RECIP_ONE / 64'd7);
  localparam logic [Y_W-1:0] RECIP_9  = Y_W'(RECIP_ONE / 64'd9);
  localparam logic [Y_W-1:0] RECIP_15 = Y_W'(RECIP_ONE / 64'd15);
  localparam logic [Y_W-1:0] RECIP_21 = Y_W'(RECIP_ONE / 64'd21);

  typedef enum logic [1:0] {
    REGION_LOW  = 2'd0,
    REGION_MID  = 2'd1,
    REGION_HIGH = 2'd2,
    REGION_NONE = 2'd3
  } region_e;

  typedef struct packed {
    region_e region;
    logic    bad;
  } side_t;

  // Gain times half-unit integration time, split as odd * 2^shift.
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [ODD_W-1:0]   odd;
  } den_t;

  function automatic den_t den_decode(input logic [CFG_W-1:0] gain,
                                      input logic [CFG_W-1:0] integ);
    logic [2:0] gs;
    logic [1:0] go;
    logic [1:0] hs;
    logic [2:0] ho;
    den_t       d;
    unique case (gain) inside
      GAIN_X1:              begin gs = 3'd0; go = 2'd1; end
      GAIN_X2:              begin gs = 3'd1; go = 2'd1; end
      GAIN_X4:              begin gs = 3'd2; go = 2'd1; end
      GAIN_X8:              begin gs = 3'd3; go = 2'd1; end
      GAIN_X48:             begin gs = 3'd4; go = 2'd3; end
      GAIN_X96:             begin gs = 3'd5; go = 2'd3; end
      GAIN_RSV4, GAIN_RSV5: begin gs = 3'd0; go = 2'd1; end
      default:              begin gs = 3'd0; go = 2'd1; end
    endcase
    unique case (integ)
      INTEG_T1:  begin hs = 2'd1; ho = 3'd1; end
      INTEG_T05: begin hs = 2'd0; ho = 3'd1; end
      INTEG_T2:  begin hs = 2'd2; ho = 3'd1; end
      INTEG_T4:  begin hs = 2'd3; ho = 3'd1; end
      INTEG_T15: begin hs = 2'd0; ho = 3'd3; end
      INTEG_T25: begin hs = 2'd0; ho = 3'd5; end
      INTEG_T3:  begin hs = 2'd1; ho = 3'd3; end
      INTEG_T35: begin hs = 2'd0; ho = 3'd7; end
      default:   begin hs = 2'd0; ho = 3'd1; end
    endcase
    d.shift = SHIFT_W'(gs) + SHIFT_W'(hs);
    d.odd   = ODD_W'(go) * ODD_W'(ho);
    return d;
  endfunction

  function automatic logic [Y_W-1:0] recip(input logic [ODD_W-1:0] odd);
    logic [Y_W-1:0] r;
    case (odd)
      5'd3:    r = RECIP_3;
      5'd5:    r = RECIP_5;
      5'd7:    r = RECIP_7;
      5'd9:    r = RECIP_9;
      5'd15:   r = RECIP_15;
      5'd21:   r = RECIP_21;
      default: r = RECIP_1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ambient_light_lux_calc.sv
// Top level of the ambient light lux calculator: configuration, region and formula stages.
`default_nettype none

// Converts one pair of raw light counts into lux (8 fraction bits), the share
// region and a reserved-gain flag. It takes one beat per clock unless the
// output is held by out_ready_i, and hands out the results in order; the five
// register stages are region compare, coefficient products, sum and scale,
// reciprocal multiply (a 32x32 product, the deepest stage), and correction
// with saturation. Gain and integration codes are read as each pair enters
// and should only be written while nothing is in flight.

module ambient_light_lux_calc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [alc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [alc_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [alc_pkg::CNT_W-1:0]         full_count_i,
  input  logic [alc_pkg::CNT_W-1:0]         ir_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [alc_pkg::LUX_W-1:0]         lux_q8_o,
  output logic [1:0]                        region_o,
  output logic                              invalid_gain_o
);

`include "ambient_light_lux_calc_assert.svh"

  logic [alc_pkg::CFG_W-1:0] gain_q, gain_d, integ_q, integ_d;

  always_comb begin
    gain_d  = gain_q;
    integ_d = integ_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        alc_pkg::REG_GAIN:  gain_d  = cfg_wdata_i;
        alc_pkg::REG_INTEG: integ_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= '0;
      integ_q <= '0;
    end else begin
      gain_q  <= gain_d;
      integ_q <= integ_d;
    end
  end

  // Stage 1: region from exact integer comparison of the infrared share.
  logic [alc_pkg::TOTAL_W-1:0] total;
  logic [alc_pkg::CMP_W-1:0]   ir_pct;
  alc_pkg::region_e            region_in;
  alc_pkg::den_t               den_in;

  always_comb begin
    total  = alc_pkg::TOTAL_W'(full_count_i) + alc_pkg::TOTAL_W'(ir_count_i);
    ir_pct = alc_pkg::CMP_W'(ir_count_i) * alc_pkg::SHARE_SCALE;
    den_in = alc_pkg::den_decode(gain_q, integ_q);
    if (total == '0) begin
      region_in = alc_pkg::REGION_NONE;
    end else if (ir_pct < alc_pkg::CMP_W'(total) * alc_pkg::SHARE_LOW) begin
      region_in = alc_pkg::REGION_LOW;
    end else if (ir_pct < alc_pkg::CMP_W'(total) * alc_pkg::SHARE_MID) begin
      region_in = alc_pkg::REGION_MID;
    end else if (ir_pct < alc_pkg::CMP_W'(total) * alc_pkg::SHARE_HIGH) begin
      region_in = alc_pkg::REGION_HIGH;
    end else begin
      region_in = alc_pkg::REGION_NONE;
    end
  end

  logic                          v1_q, v2_q, v3_q;
  logic                          en1, en2, en3, div_ready;
  logic [alc_pkg::CNT_W-1:0]     full1_q, ir1_q;
  alc_pkg::side_t                side1_q, side2_q, side3_q;
  alc_pkg::den_t                 den1_q, den2_q;
  logic [alc_pkg::ODD_W-1:0]     odd3_q;
  logic [alc_pkg::PROD_W-1:0]    pa_q, pb_q, pa_d, pb_d;
  logic [alc_pkg::Y_W-1:0]       y_q, y_d;

  assign en3        = !v3_q || div_ready;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // Stage 2: the two coefficient products of the selected formula.
  always_comb begin
    logic [alc_pkg::COEF_W-1:0] ca;
    logic [alc_pkg::COEF_W-1:0] cb;
    case (side1_q.region)
      alc_pkg::REGION_LOW:  begin ca = alc_pkg::COEF_A0; cb = alc_pkg::COEF_B0; end
      alc_pkg::REGION_MID:  begin ca = alc_pkg::COEF_A1; cb = alc_pkg::COEF_B1; end
      alc_pkg::REGION_HIGH: begin ca = alc_pkg::COEF_A2; cb = alc_pkg::COEF_B2; end
      default:              begin ca = '0;               cb = '0;               end
    endcase
    pa_d = alc_pkg::PROD_W'(ca) * alc_pkg::PROD_W'(full1_q);
    pb_d = alc_pkg::PROD_W'(cb) * alc_pkg::PROD_W'(ir1_q);
  end

  // Stage 3: signed combination, output scaling and the power-of-two part
  // of the denominator; the odd part is left to the divider.
  always_comb begin
    logic [alc_pkg::SUM_W-1:0] sum;
    logic [alc_pkg::EXT_W-1:0] scaled;
    if (side2_q.region == alc_pkg::REGION_MID) begin
      sum = (pa_q > pb_q) ? alc_pkg::SUM_W'(pa_q) - alc_pkg::SUM_W'(pb_q) : '0;
    end else begin
      sum = alc_pkg::SUM_W'(pa_q) + alc_pkg::SUM_W'(pb_q);
    end
    scaled = alc_pkg::EXT_W'(sum) << (alc_pkg::OUT_FRAC_BITS + 1);
    scaled = scaled >> alc_pkg::COEF_FRAC_BITS;
    scaled = scaled >> den2_q.shift;
    if (scaled > alc_pkg::EXT_W'(alc_pkg::Y_CLAMP)) begin
      y_d = alc_pkg::Y_CLAMP;
    end else begin
      y_d = scaled[alc_pkg::Y_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      full1_q        <= full_count_i;
      ir1_q          <= ir_count_i;
      side1_q.region <= region_in;
      side1_q.bad    <= (gain_q == alc_pkg::GAIN_RSV4) || (gain_q == alc_pkg::GAIN_RSV5);
      den1_q         <= den_in;
    end
    if (en2 && v1_q) begin
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      side2_q <= side1_q;
      den2_q  <= den1_q;
    end
    if (en3 && v2_q) begin
      y_q     <= y_d;
      odd3_q  <= den2_q.odd;
      side3_q <= side2_q;
    end
  end

  alc_pkg::side_t side_out;

  alc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_ready_o  (div_ready),
    .y_i         (y_q),
    .odd_i       (odd3_q),
    .side_i      (side3_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .lux_q8_o    (lux_q8_o),
    .side_o      (side_out)
  );

  assign region_o       = side_out.region;
  assign invalid_gain_o = side_out.bad;

  `ALC_ASSERT_ALWAYS(a_no_region_zero_lux,
    !(out_valid_o && (region_o == alc_pkg::REGION_NONE)) || (lux_q8_o == '0))
  `ALC_ASSERT_ALWAYS(a_bad_gain_saturates,
    !(out_valid_o && invalid_gain_o && (region_o != alc_pkg::REGION_NONE))
      || (lux_q8_o == alc_pkg::LUX_MAX))
  `ALC_ASSERT_NEXT(a_stage1_holds, v1_q && !en2, v1_q && $stable(side1_q))

endmodule

`default_nettype wire

FILE: rtl/core/alc_div.sv
// Two-stage divider by a small odd constant: reciprocal multiply, then one correction step and the output clamps.
`default_nettype none

module alc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [alc_pkg::Y_W-1:0]         y_i,
  input  logic [alc_pkg::ODD_W-1:0]       odd_i,
  input  alc_pkg::side_t                  side_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [alc_pkg::LUX_W-1:0]       lux_q8_o,
  output alc_pkg::side_t                  side_o
);

  localparam int unsigned PW = 2 * alc_pkg::Y_W;
  localparam int unsigned MW = alc_pkg::Y_W + alc_pkg::ODD_W;

  logic                        v4_q, v5_q;
  logic                        en4, en5;
  logic [alc_pkg::Y_W-1:0]     y4_q, q0_q;
  logic [alc_pkg::ODD_W-1:0]   odd4_q;
  alc_pkg::side_t              side4_q, side5_q;
  logic [alc_pkg::LUX_W-1:0]   lux_q, lux_d;

  logic [PW-1:0]               prod;
  logic [MW-1:0]               qm;
  logic [alc_pkg::Y_W-1:0]     rem;
  logic [alc_pkg::Y_W:0]       qt;

  assign en5        = !v5_q || out_ready_i;
  assign en4        = !v4_q || en5;
  assign in_ready_o = en4;

  // The reciprocal undershoots 2^32/odd by at most one, so the product gives q or q-1.
  assign prod = PW'(y_i) * PW'(alc_pkg::recip(odd_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en4) v4_q <= in_valid_i;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && in_valid_i) begin
      y4_q    <= y_i;
      odd4_q  <= odd_i;
      side4_q <= side_i;
      q0_q    <= prod[PW-1:alc_pkg::Y_W];
    end
    if (en5 && v4_q) begin
      side5_q <= side4_q;
      lux_q   <= lux_d;
    end
  end

  always_comb begin
    qm  = MW'(q0_q) * MW'(odd4_q);
    rem = y4_q - qm[alc_pkg::Y_W-1:0];
    qt  = (alc_pkg::Y_W + 1)'(q0_q)
        + (alc_pkg::Y_W + 1)'(rem >= alc_pkg::Y_W'(odd4_q));
    if (side4_q.region == alc_pkg::REGION_NONE) begin
      lux_d = '0;
    end else if (side4_q.bad) begin
      lux_d = alc_pkg::LUX_MAX;
    end else if (qt > (alc_pkg::Y_W + 1)'(alc_pkg::LUX_MAX)) begin
      lux_d = alc_pkg::LUX_MAX;
    end else begin
      lux_d = qt[alc_pkg::LUX_W-1:0];
    end
  end

  assign out_valid_o = v5_q;
  assign lux_q8_o    = lux_q;
  assign side_o      = side5_q;

endmodule

`default_nettype wire
